// File: design/ssched_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stride scheduler select: shared package
// Command codes, field widths, default sizes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ssched_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int PASS_BITS_DEF = 31;

	localparam int CMD_W     = 3;
	localparam int SLOT_W    = 6;
	localparam int TICKET_W  = 14;
	localparam int STRIDE_W  = 16;
	localparam int NUM_W     = 16;
	// wide enough to compare a slot field against any table size up to 256
	localparam int SLOT_CMP_W = 9;

	localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(10000);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADMIT   = 3'd0,
		CMD_RUN     = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_PICK    = 3'd4
	} cmd_t;

	typedef struct packed {
		logic admit;
		logic set_run;
		logic clr_run;
		logic rel;
		logic bump;
	} ssched_ctl_t;

endpackage
`default_nettype wire

// File: design/ssched_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stride scheduler select: serial divider
// Restoring divide, one quotient bit per cycle, numerator / tickets.
// ----------------------------------------------------------------------------
module ssched_div
	import ssched_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_W-1:0]    num,
	input  wire logic [TICKET_W-1:0] den,
	output logic                     done,
	output logic [STRIDE_W-1:0]      quot
);

	localparam int STEP_W = $clog2(NUM_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [TICKET_W-1:0] den_q;
	logic [TICKET_W-1:0] rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [TICKET_W:0]   trial;
	logic [TICKET_W:0]   diff;
	logic                fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TICKET_W-1:0] : trial[TICKET_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = STRIDE_W'(quo_q);

endmodule
`default_nettype wire

// File: design/ssched_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stride scheduler select: slot cell
// Holds one slot's pass, stride and flags; passes the running minimum on.
// ----------------------------------------------------------------------------
module ssched_cell
	import ssched_pkg::*;
#(
	parameter int PASS_BITS = PASS_BITS_DEF,
	parameter int IDX_W     = 6,
	parameter int CELL_IDX  = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ssched_ctl_t          ctl,
	input  wire logic                 sel,
	input  wire logic [STRIDE_W-1:0]  stride_in,
	input  wire logic                 found_in,
	input  wire logic [PASS_BITS-1:0] pass_in,
	input  wire logic [IDX_W-1:0]     idx_in,
	output logic                      found_out,
	output logic [PASS_BITS-1:0]      pass_out,
	output logic [IDX_W-1:0]          idx_out,
	output logic                      active
);

	logic                 active_q;
	logic                 run_q;
	logic [PASS_BITS-1:0] pass_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic                 found_q;
	logic [PASS_BITS-1:0] best_pass_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [PASS_BITS:0]   sum;
	logic                 take;

	assign sum  = {1'b0, pass_q} + (PASS_BITS + 1)'(stride_q);
	assign take = run_q && (!found_in || (pass_q < pass_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			run_q    <= 1'b0;
			pass_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			found_q <= found_in | run_q;
			if (sel) begin
				if (ctl.admit) begin
					active_q <= 1'b1;
					run_q    <= 1'b0;
					pass_q   <= '0;
				end
				if (ctl.set_run)
					run_q <= 1'b1;
				if (ctl.clr_run)
					run_q <= 1'b0;
				if (ctl.rel) begin
					active_q <= 1'b0;
					run_q    <= 1'b0;
					pass_q   <= '0;
				end
				if (ctl.bump)
					pass_q <= sum[PASS_BITS] ? '0 : sum[PASS_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctl.admit)
			stride_q <= stride_in;
		best_pass_q <= take ? pass_q : pass_in;
		best_idx_q  <= take ? IDX_W'(CELL_IDX) : idx_in;
	end

	assign found_out = found_q;
	assign pass_out  = best_pass_q;
	assign idx_out   = best_idx_q;
	assign active    = active_q;

endmodule
`default_nettype wire

// File: design/stride_scheduler_select_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stride scheduler select: top level
// Slot table as a chain of cells with a running-minimum scan, serial divider
// for admit strides, one output register.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   cmd, slot, tickets
//  out       out_valid / out_stall chosen_slot, chosen_found, status
//  cfg       cfg_we                cfg_wdata (stride numerator)
//
//  Run/stop/release/undefined and a rejected admit: go straight from idle to the result state.
//  Admit: waits on the 16-step divider, then writes the new stride.
//  Pick: waits while the scan ripples down the chain.
//  Reset is asynchronous; the numerator returns to 10000, all slots inactive.
//  A request is taken only while no earlier one is in flight; a finished
//  result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module stride_scheduler_select_core
	import ssched_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int PASS_BITS = PASS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [NUM_W-1:0]    cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [SLOT_W-1:0]   slot,
	input  wire logic [TICKET_W-1:0] tickets,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [SLOT_W-1:0]        chosen_slot,
	output logic                     chosen_found,
	output logic                     status
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    slot_q;
	logic [NUM_W-1:0]    num_q;
	logic                res_found_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_status_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_status_q;

	logic                acc;
	logic                in_tab;
	logic [IDX_W-1:0]    slot_idx;
	logic                act_hit;
	logic                div_start;
	logic                div_done;
	logic [STRIDE_W-1:0] div_quot;
	logic                scan_done;
	logic                out_load;
	ssched_ctl_t         ctl;
	logic [IDX_W-1:0]    tgt;
	logic [SLOTS-1:0]    sel;
	logic [SLOTS-1:0]    act;

	logic                 found_c [SLOTS+1];
	logic [PASS_BITS-1:0] pass_c  [SLOTS+1];
	logic [IDX_W-1:0]     idx_c   [SLOTS+1];

	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign in_tab    = (SLOT_CMP_W'(slot) < SLOT_CMP_W'(SLOTS));
	assign slot_idx  = IDX_W'(slot);
	assign act_hit   = in_tab && act[slot_idx];
	assign div_start = acc && (cmd_t'(cmd) == CMD_ADMIT) && in_tab && (tickets != '0);
	assign scan_done = (state_q == ST_SCAN) && (cnt_q == CNT_W'(SLOTS));
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		ctl = '0;
		tgt = slot_idx;
		if (acc) begin
			case (cmd_t'(cmd))
				CMD_RUN:     ctl.set_run = act_hit;
				CMD_STOP:    ctl.clr_run = act_hit;
				CMD_RELEASE: ctl.rel     = act_hit;
				default:     ctl         = '0;
			endcase
		end
		if ((state_q == ST_DIV) && div_done) begin
			ctl.admit = 1'b1;
			tgt       = slot_q;
		end
		if (scan_done && found_c[SLOTS]) begin
			ctl.bump = 1'b1;
			tgt      = idx_c[SLOTS];
		end
	end

	ssched_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (tickets),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign found_c[0] = 1'b0;
	assign pass_c[0]  = '0;
	assign idx_c[0]   = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		assign sel[i] = (tgt == IDX_W'(i));
		ssched_cell #(
			.PASS_BITS (PASS_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (sel[i]),
			.stride_in (div_quot),
			.found_in  (found_c[i]),
			.pass_in   (pass_c[i]),
			.idx_in    (idx_c[i]),
			.found_out (found_c[i+1]),
			.pass_out  (pass_c[i+1]),
			.idx_out   (idx_c[i+1]),
			.active    (act[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_q <= NUM_RESET;
		else if (cfg_we)
			num_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						slot_q      <= slot_idx;
						res_found_q <= 1'b0;
						res_slot_q  <= '0;
						cnt_q       <= '0;
						case (cmd_t'(cmd))
							CMD_ADMIT: begin
								res_status_q <= !div_start;
								state_q      <= div_start ? ST_DIV : ST_FIN;
							end
							CMD_RUN, CMD_STOP, CMD_RELEASE: begin
								res_status_q <= !act_hit;
								state_q      <= ST_FIN;
							end
							CMD_PICK: begin
								res_status_q <= 1'b0;
								state_q      <= ST_SCAN;
							end
							default: begin
								res_status_q <= 1'b1;
								state_q      <= ST_FIN;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (scan_done) begin
						res_found_q <= found_c[SLOTS];
						res_slot_q  <= found_c[SLOTS] ? SLOT_W'(idx_c[SLOTS]) : '0;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_found_q  <= res_found_q;
						out_slot_q   <= res_slot_q;
						out_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_slot  = out_slot_q;
	assign chosen_found = out_found_q;
	assign status       = out_status_q;

`ifndef SYNTHESIS
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chosen_found |-> !status)
		else $error("found result marked rejected");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chosen_found |-> chosen_slot == '0)
		else $error("slot nonzero without a find");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside admit");

	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel & {SLOTS{|ctl}}) && $onehot0(ctl))
		else $error("more than one cell update");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid_q && out_stall |=> state_q == ST_FIN)
		else $error("result left while output held");
`endif

endmodule
`default_nettype wire
